@@ src/pidc_pkg.sv @@
package pidc_pkg;

    // fixed field widths
    localparam int PIDC_DATA_W    = 32;   // setpoint, gains, measured value, drive
    localparam int PIDC_DT_W      = 31;   // tolerance and sample period
    localparam int PIDC_ERR_W     = 33;   // error and last error
    localparam int PIDC_DE_W      = 34;   // error difference
    localparam int PIDC_INTEG_W   = 48;   // integral accumulator
    localparam int PIDC_TERM_W    = 60;   // magnitude of a scaled product, clipped
    localparam int PIDC_SUM_W     = 63;   // sum of three signed terms
    localparam int PIDC_CFG_IDX_W = 3;

    // default fraction bits of the fixed-point format
    localparam int PIDC_FRAC_BITS = 16;

    // drive value reported inside the deadband, in whole units
    localparam int PIDC_MARKER = -100;

    typedef enum logic [PIDC_CFG_IDX_W-1:0] {
        CFG_TARGET     = 3'd0,
        CFG_GAIN_PROP  = 3'd1,
        CFG_GAIN_INTEG = 3'd2,
        CFG_GAIN_DERIV = 3'd3,
        CFG_TOLERANCE  = 3'd4,
        CFG_STEP_TIME  = 3'd5
    } t_cfg_idx;

endpackage

@@ src/pid_controller_with_deadband_top.sv @@
// PID controller with deadband, signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default). Write the six registers (setpoint, three gains,
// tolerance, sample period) while the block is idle. A sample word with
// func=0 forms error = setpoint - measured; if |error| < tolerance the state
// is held and one result word with drive = -100.0 and within_tolerance=1 is
// returned. Otherwise the integral and last error are updated and drive =
// kp*e + ki*integral + kd*(e - previous)/dt is returned, saturated; the
// saturated flag marks any clipped term, integral or drive. A word with
// func=1 clears the integral and returns nothing. One 32x32 multiplier is
// shared by the four products, and the rate (e-prev)/dt comes from a
// radix-4 serial divider that runs beside the first three products. The
// input is not ready until the result word has moved into the output
// register.
module pid_controller_with_deadband_top #(
    parameter int FRAC_BITS = pidc_pkg::PIDC_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [pidc_pkg::PIDC_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pidc_pkg::PIDC_DATA_W-1:0]       i_cfg_data,
    // sample channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_func,
    input  logic signed [pidc_pkg::PIDC_DATA_W-1:0] i_measured,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pidc_pkg::PIDC_DATA_W-1:0] o_drive,
    output logic                                   o_within_tolerance,
    output logic                                   o_saturated
);
    import pidc_pkg::*;

    localparam int DIV_W = ((PIDC_DE_W + FRAC_BITS + 1) / 2) * 2;
    localparam int B_W   = (DIV_W > PIDC_INTEG_W) ? DIV_W : PIDC_INTEG_W;
    localparam int BH_W  = B_W - PIDC_DATA_W;
    localparam int P_W   = PIDC_DATA_W + B_W;
    localparam int CLIP_LSB = PIDC_TERM_W + FRAC_BITS;
    localparam logic signed [PIDC_DATA_W-1:0] MARKER =
        PIDC_DATA_W'(PIDC_MARKER * (2 ** FRAC_BITS));
    localparam logic [PIDC_DT_W-1:0] STEP_RESET = PIDC_DT_W'(2 ** FRAC_BITS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_MLO   = 8'b0000_0100,
        S_MHI   = 8'b0000_1000,
        S_NORM  = 8'b0001_0000,
        S_APPLY = 8'b0010_0000,
        S_FINAL = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_INC = 2'd0,
        OP_P   = 2'd1,
        OP_I   = 2'd2,
        OP_D   = 2'd3
    } t_op;

    function automatic logic [PIDC_DATA_W-1:0] mag32(input logic [PIDC_DATA_W-1:0] x);
        mag32 = x[PIDC_DATA_W-1] ? (~x + PIDC_DATA_W'(1)) : x;
    endfunction

    // configuration registers
    logic signed [PIDC_DATA_W-1:0] r_target, r_kp, r_ki, r_kd;
    logic [PIDC_DT_W-1:0]          r_tol, r_step_time;

    // controller state
    logic signed [PIDC_ERR_W-1:0]   r_last_err;
    logic signed [PIDC_INTEG_W-1:0] r_integ;

    // sequencer and datapath
    t_state                        r_state, n_state;
    t_op                           r_op;
    logic signed [PIDC_ERR_W-1:0]  r_err;
    logic                          r_de_neg;
    logic                          r_neg;
    logic [2*PIDC_DATA_W-1:0]      r_plo;
    logic [PIDC_DATA_W+BH_W-1:0]   r_phi;
    logic [PIDC_TERM_W-1:0]        r_mag;
    logic signed [PIDC_SUM_W-1:0]  r_sum;
    logic                          r_clip;
    logic signed [PIDC_DATA_W-1:0] r_res_drive;
    logic                          r_res_within, r_res_sat;

    // output register
    logic                          r_out_valid;
    logic signed [PIDC_DATA_W-1:0] r_drive;
    logic                          r_within, r_sat;

    logic                          in_acc, out_free, in_band;
    logic [PIDC_DT_W-1:0]          dt;
    logic [PIDC_ERR_W-1:0]         err_mag;
    logic signed [PIDC_DE_W-1:0]   de;
    logic [PIDC_DE_W-1:0]          de_mag;
    logic [PIDC_INTEG_W-1:0]       integ_mag;
    logic [DIV_W-1:0]              div_dividend, div_quot;
    logic                          div_start, div_busy;
    logic [PIDC_DATA_W-1:0]        op_a;
    logic [B_W-1:0]                op_b;
    logic                          op_neg;
    logic [PIDC_DATA_W-1:0]        mul_b;
    logic [2*PIDC_DATA_W-1:0]      mul_p;
    logic [P_W-1:0]                prod;
    logic signed [PIDC_TERM_W:0]   term_pos, term;
    logic signed [PIDC_INTEG_W+13:0] isum;
    logic                          isum_ovf, sum_ovf;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign dt        = (r_step_time == '0) ? PIDC_DT_W'(1) : r_step_time;
    assign err_mag   = r_err[PIDC_ERR_W-1] ? PIDC_ERR_W'(-r_err) : PIDC_ERR_W'(r_err);
    assign in_band   = (r_tol != '0) && (err_mag < PIDC_ERR_W'(r_tol));
    assign de        = PIDC_DE_W'(r_err) - PIDC_DE_W'(r_last_err);
    assign de_mag    = de[PIDC_DE_W-1] ? PIDC_DE_W'(-de) : PIDC_DE_W'(de);
    assign integ_mag = r_integ[PIDC_INTEG_W-1] ? PIDC_INTEG_W'(-r_integ)
                                               : PIDC_INTEG_W'(r_integ);

    assign div_start    = (r_state == S_CHECK) && !in_band;
    assign div_dividend = DIV_W'(de_mag) << FRAC_BITS;

    pidc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (dt),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // operands of the shared multiplier
    always_comb begin
        unique case (r_op)
            OP_INC: begin
                op_a   = PIDC_DATA_W'(dt);
                op_b   = B_W'(err_mag);
                op_neg = r_err[PIDC_ERR_W-1];
            end
            OP_P: begin
                op_a   = mag32(r_kp);
                op_b   = B_W'(err_mag);
                op_neg = r_kp[PIDC_DATA_W-1] ^ r_err[PIDC_ERR_W-1];
            end
            OP_I: begin
                op_a   = mag32(r_ki);
                op_b   = B_W'(integ_mag);
                op_neg = r_ki[PIDC_DATA_W-1] ^ r_integ[PIDC_INTEG_W-1];
            end
            OP_D: begin
                op_a   = mag32(r_kd);
                op_b   = B_W'(div_quot);
                op_neg = r_kd[PIDC_DATA_W-1] ^ r_de_neg;
            end
        endcase
    end

    // low half of the operand first, then the high half
    assign mul_b = (r_state == S_MHI) ? PIDC_DATA_W'(op_b[B_W-1:PIDC_DATA_W])
                                      : op_b[PIDC_DATA_W-1:0];
    assign mul_p = op_a * mul_b;

    always_comb begin
        prod     = {r_phi, {PIDC_DATA_W{1'b0}}} + P_W'(r_plo);
        term_pos = {1'b0, r_mag};
        term     = r_neg ? -term_pos : term_pos;
        isum     = (PIDC_INTEG_W+14)'(r_integ) + (PIDC_INTEG_W+14)'(term);
        isum_ovf = !((&isum[PIDC_INTEG_W+13:PIDC_INTEG_W-1])
                  || !(|isum[PIDC_INTEG_W+13:PIDC_INTEG_W-1]));
        sum_ovf  = !((&r_sum[PIDC_SUM_W-1:PIDC_DATA_W-1])
                  || !(|r_sum[PIDC_SUM_W-1:PIDC_DATA_W-1]));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && !i_func) n_state = S_CHECK;
            S_CHECK: n_state = in_band ? S_OUT : S_MLO;
            S_MLO:   if (!(r_op == OP_D && div_busy)) n_state = S_MHI;
            S_MHI:   n_state = S_NORM;
            S_NORM:  n_state = S_APPLY;
            S_APPLY: n_state = (r_op == OP_D) ? S_FINAL : S_MLO;
            S_FINAL: n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_tol       <= '0;
            r_step_time <= STEP_RESET;
            r_last_err  <= '0;
            r_integ     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TARGET:     r_target    <= i_cfg_data;
                    CFG_GAIN_PROP:  r_kp        <= i_cfg_data;
                    CFG_GAIN_INTEG: r_ki        <= i_cfg_data;
                    CFG_GAIN_DERIV: r_kd        <= i_cfg_data;
                    CFG_TOLERANCE:  r_tol       <= i_cfg_data[PIDC_DT_W-1:0];
                    CFG_STEP_TIME:  r_step_time <= i_cfg_data[PIDC_DT_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc && i_func) begin
                r_integ <= '0;
            end
            if (r_state == S_CHECK && !in_band) begin
                r_last_err <= r_err;
            end
            if (r_state == S_APPLY && r_op == OP_INC) begin
                if (isum_ovf) begin
                    r_integ <= isum[PIDC_INTEG_W+13]
                        ? {1'b1, {(PIDC_INTEG_W-1){1'b0}}}
                        : {1'b0, {(PIDC_INTEG_W-1){1'b1}}};
                end else begin
                    r_integ <= isum[PIDC_INTEG_W-1:0];
                end
            end

            // drop the word on acceptance, a new load takes priority
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_func) begin
            r_err <= PIDC_ERR_W'(r_target) - PIDC_ERR_W'(i_measured);
        end

        unique case (r_state)
            S_CHECK: begin
                r_op     <= OP_INC;
                r_clip   <= 1'b0;
                r_sum    <= '0;
                r_de_neg <= de[PIDC_DE_W-1];
                if (in_band) begin
                    r_res_drive  <= MARKER;
                    r_res_within <= 1'b1;
                    r_res_sat    <= 1'b0;
                end
            end
            S_MLO: begin
                r_plo <= mul_p;
                r_neg <= op_neg;
            end
            S_MHI: begin
                r_phi <= mul_p[PIDC_DATA_W+BH_W-1:0];
            end
            S_NORM: begin
                if (|prod[P_W-1:CLIP_LSB]) begin
                    r_mag  <= '1;
                    r_clip <= 1'b1;
                end else begin
                    r_mag <= prod[CLIP_LSB-1:FRAC_BITS];
                end
            end
            S_APPLY: begin
                unique case (r_op)
                    OP_INC: begin
                        if (isum_ovf) r_clip <= 1'b1;
                        r_op <= OP_P;
                    end
                    OP_P: begin
                        r_sum <= r_sum + PIDC_SUM_W'(term);
                        r_op  <= OP_I;
                    end
                    OP_I: begin
                        r_sum <= r_sum + PIDC_SUM_W'(term);
                        r_op  <= OP_D;
                    end
                    OP_D: begin
                        r_sum <= r_sum + PIDC_SUM_W'(term);
                    end
                endcase
            end
            S_FINAL: begin
                r_res_within <= 1'b0;
                r_res_sat    <= r_clip || sum_ovf;
                if (sum_ovf) begin
                    r_res_drive <= r_sum[PIDC_SUM_W-1]
                        ? {1'b1, {(PIDC_DATA_W-1){1'b0}}}
                        : {1'b0, {(PIDC_DATA_W-1){1'b1}}};
                end else begin
                    r_res_drive <= r_sum[PIDC_DATA_W-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_drive  <= r_res_drive;
                    r_within <= r_res_within;
                    r_sat    <= r_res_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive            = r_drive;
    assign o_within_tolerance = r_within;
    assign o_saturated        = r_sat;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_clear_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func) |=> (r_integ == '0) && (r_state == S_IDLE))
        else $error("clear word did not zero the integral");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_within_tolerance) |-> (o_drive == MARKER) && !o_saturated)
        else $error("deadband word carries a wrong drive");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FINAL) |-> !div_busy)
        else $error("divider still busy after the derivative term");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_func) |=> (r_state == S_CHECK))
        else $error("sample word did not start the sequence");

endmodule

@@ src/pidc_div.sv @@
module pidc_div #(
    parameter int DIV_W = 50
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [DIV_W-1:0]                 i_dividend,
    input  logic [pidc_pkg::PIDC_DT_W-1:0]   i_divisor,
    output logic                             o_busy,
    output logic [DIV_W-1:0]                 o_quot
);
    import pidc_pkg::*;

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [PIDC_DT_W-1:0]  r_rem;
    logic [PIDC_DT_W-1:0]  r_dvs;
    logic [DIV_W-1:0]      r_dq;

    logic [PIDC_DT_W:0]    t1, t2, dvs_ext;
    logic                  ge1, ge2;
    logic [PIDC_DT_W-1:0]  rem1, n_rem;
    logic [DIV_W-1:0]      n_dq;

    // two restoring steps per cycle; dividend shifts out MSB first,
    // quotient bits shift in at the bottom of the same register
    always_comb begin
        dvs_ext = {1'b0, r_dvs};
        t1      = {r_rem, r_dq[DIV_W-1]};
        ge1     = (t1 >= dvs_ext);
        rem1    = ge1 ? PIDC_DT_W'(t1 - dvs_ext) : t1[PIDC_DT_W-1:0];
        t2      = {rem1, r_dq[DIV_W-2]};
        ge2     = (t2 >= dvs_ext);
        n_rem   = ge2 ? PIDC_DT_W'(t2 - dvs_ext) : t2[PIDC_DT_W-1:0];
        n_dq    = {r_dq[DIV_W-3:0], ge1, ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dq;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && (r_cnt == CNT_W'(STEPS)))
        else $error("divider did not start");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_W'(1) && !i_start) |=> !r_busy)
        else $error("divider ran past its last step");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0))
        else $error("divider count left over while idle");

endmodule
